// ===== rtl/core/uqpe_pkg.sv =====
// shared types, constants and helpers of the url query parameter extractor
package uqpe_pkg;

  localparam int MAX_NAME_LEN = 8;
  localparam int NAME_W       = 8 * MAX_NAME_LEN;
  localparam int NPOS_W       = $clog2(MAX_NAME_LEN + 1);
  localparam int NSEL_W       = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    CFG_NAME_CHARS  = 2'd0,
    CFG_NAME_LENGTH = 2'd1,
    CFG_BUFFER_SIZE = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    PH_MATCH = 6'b000001,
    PH_SKIP  = 6'b000010,
    PH_VALUE = 6'b000100,
    PH_ESC1  = 6'b001000,
    PH_ESC2  = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value_byte;
    status_t    status;
    logic       last_item;
  } item_t;

  // loose hex conversion, wraps modulo 256
  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    if (c < 8'h3A) v = c - 8'h30;
    else if (c > 8'h60) v = c - 8'h57;
    else v = c - 8'h37;
    return v;
  endfunction

endpackage

// ===== rtl/core/url_query_parameter_extractor.sv =====
// top level: query string field matcher and percent decoder with result queue
//
// Takes one query string byte per request and can take a request in every cycle. A byte
// is handled in the cycle it is accepted: the name match, '+' and '%' decoding and the
// length check are short logic from the phase registers to a 4-entry result queue. Most
// requests give zero or one result; the byte marked end_of_string gives its decoded byte
// (if any) and then the status result with tlast. in_tready is high while the queue
// has room for two results, so with out_tready held high the input never stalls; a stall
// on the output side stops the input once three results are waiting. Configuration
// writes are always taken (cfg_ready is tied high) and apply from the next byte.
module url_query_parameter_extractor
  import uqpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] value_byte, [9:8] status, [15:10] zero
  output logic        out_tuser,  // item_kind
  output logic        out_tlast,  // last_item
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // configuration
  logic [NAME_W-1:0] name_chars_r;
  logic [3:0]        name_length_r;
  logic [7:0]        buffer_size_r;

  // per-string state
  phase_t            phase_r, phase_nxt;
  logic [NPOS_W-1:0] name_pos_r, name_pos_nxt;
  logic [7:0]        high_digit_r, high_digit_nxt;
  logic [7:0]        emitted_r, emitted_nxt;
  status_t           outcome_r, outcome_nxt;

  // result queue
  item_t              q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  logic              in_fire, out_fire;
  logic [NPOS_W-1:0] len;
  logic [7:0]        name_ch;
  logic              emit_req, emit_v;
  logic [7:0]        emit_b;
  logic [7:0]        esc_byte;
  item_t             push0, push1;
  logic              push0_v, push1_v;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign in_tready = count_r <= Q_CNT_W'(Q_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_chars_r  <= '0;
      name_length_r <= 4'd1;
      buffer_size_r <= 8'd33;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NAME_CHARS:  name_chars_r  <= cfg_data[NAME_W-1:0];
        CFG_NAME_LENGTH: name_length_r <= cfg_data[3:0];
        CFG_BUFFER_SIZE: buffer_size_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign len = (name_length_r > 4'(MAX_NAME_LEN)) ? NPOS_W'(MAX_NAME_LEN)
                                                  : NPOS_W'(name_length_r);
  assign name_ch  = name_chars_r[8*name_pos_r[NSEL_W-1:0] +: 8];
  assign esc_byte = {high_digit_r[3:0], 4'b0000} + hex_digit(in_tdata);

  always_comb begin
    phase_nxt      = phase_r;
    name_pos_nxt   = name_pos_r;
    high_digit_nxt = high_digit_r;
    emitted_nxt    = emitted_r;
    outcome_nxt    = outcome_r;
    emit_req       = 1'b0;
    emit_b         = in_tdata;

    unique case (phase_r)
      PH_MATCH: begin
        if (name_pos_r < len) begin
          if (in_tdata == name_ch) name_pos_nxt = name_pos_r + 1'b1;
          else if (in_tdata == CH_AMP) name_pos_nxt = '0;
          else phase_nxt = PH_SKIP;
        end else if (in_tdata == CH_EQUALS) begin
          if (buffer_size_r == 8'd0) begin
            outcome_nxt = ST_TOO_LONG;
            phase_nxt   = PH_DONE;
          end else begin
            outcome_nxt = ST_FOUND;
            phase_nxt   = PH_VALUE;
          end
        end else if (in_tdata == CH_AMP) begin
          name_pos_nxt = '0;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (in_tdata == CH_AMP) begin
          phase_nxt    = PH_MATCH;
          name_pos_nxt = '0;
        end
      end
      PH_VALUE: begin
        if (in_tdata == CH_AMP) begin
          phase_nxt = PH_DONE;
        end else if (in_tdata == CH_PERCENT && emitted_r < buffer_size_r) begin
          phase_nxt = PH_ESC1;
        end else begin
          // plain byte, '+', or an overfull buffer (handled below)
          emit_req = 1'b1;
          emit_b   = (in_tdata == CH_PLUS) ? CH_SPACE : in_tdata;
        end
      end
      PH_ESC1: begin
        high_digit_nxt = hex_digit(in_tdata);
        phase_nxt      = PH_ESC2;
      end
      PH_ESC2: begin
        phase_nxt = PH_VALUE;
        emit_req  = 1'b1;
        emit_b    = esc_byte;
      end
      PH_DONE: ;
      default: ;
    endcase

    emit_v = 1'b0;
    if (emit_req) begin
      if (emitted_r >= buffer_size_r) begin
        outcome_nxt = ST_TOO_LONG;
        phase_nxt   = PH_DONE;
      end else begin
        emit_v      = 1'b1;
        emitted_nxt = emitted_r + 8'd1;
        if (emitted_nxt >= buffer_size_r) begin
          outcome_nxt = ST_TOO_LONG;
          phase_nxt   = PH_DONE;
        end
      end
    end
  end

  // the byte result goes first, the status result after it
  always_comb begin
    push0.kind       = KIND_BYTE;
    push0.value_byte = emit_b;
    push0.status     = ST_FOUND;
    push0.last_item  = 1'b0;
    push1.kind       = KIND_STATUS;
    push1.value_byte = 8'd0;
    push1.status     = outcome_nxt;
    push1.last_item  = 1'b1;
    if (!emit_v) push0 = push1;
    push0_v = in_fire && (emit_v || in_tlast);
    push1_v = in_fire && emit_v && in_tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MATCH;
      name_pos_r   <= '0;
      high_digit_r <= '0;
      emitted_r    <= '0;
      outcome_r    <= ST_NOT_FOUND;
    end else if (in_fire) begin
      if (in_tlast) begin
        phase_r      <= PH_MATCH;
        name_pos_r   <= '0;
        high_digit_r <= '0;
        emitted_r    <= '0;
        outcome_r    <= ST_NOT_FOUND;
      end else begin
        phase_r      <= phase_nxt;
        name_pos_r   <= name_pos_nxt;
        high_digit_r <= high_digit_nxt;
        emitted_r    <= emitted_nxt;
        outcome_r    <= outcome_nxt;
      end
    end
  end

  always_comb begin
    count_nxt = count_r + Q_CNT_W'(push0_v) + Q_CNT_W'(push1_v) - Q_CNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + Q_PTR_W'(push0_v) + Q_PTR_W'(push1_v);
      rd_ptr_r <= rd_ptr_r + Q_PTR_W'(out_fire);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0_v) q_mem[wr_ptr_r] <= push0;
    if (push1_v) q_mem[wr_ptr_r + 1'b1] <= push1;
  end

  assign out_tvalid = count_r != '0;
  assign out_tdata  = {6'd0, q_mem[rd_ptr_r].status, q_mem[rd_ptr_r].value_byte};
  assign out_tuser  = q_mem[rd_ptr_r].kind;
  assign out_tlast  = q_mem[rd_ptr_r].last_item;

  // queue never overflows
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  // end of string returns the matcher to its start state
  a_string_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> phase_r == PH_MATCH && name_pos_r == '0 &&
                            emitted_r == '0 && outcome_r == ST_NOT_FOUND)
    else $error("state not cleared after end of string");

  // second escape digit only after the first, or while waiting for it
  a_esc_order: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ESC2 |-> $past(phase_r) == PH_ESC1 || $past(phase_r) == PH_ESC2)
    else $error("escape phase out of order");

  // status results always close the string
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_STATUS |-> out_tlast)
    else $error("status result without tlast");

  // name position never passes the name length cap
  a_name_pos: assert property (@(posedge clk) disable iff (!rst_n)
    name_pos_r <= NPOS_W'(MAX_NAME_LEN))
    else $error("name position out of range");

endmodule

// ===== bench/tb_url_query_parameter_extractor.sv =====
// self-checking bench for the query parameter extractor: random query strings, stalls
`timescale 1ns / 100ps

module tb_url_query_parameter_extractor;
  import uqpe_pkg::*;

  localparam int RANDOM_ITEMS    = 600;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;

  // expected results of the parameter search, worked out per accepted byte
  class query_value_scoreboard;
    logic [63:0] name_chars;
    logic [3:0]  name_length;
    logic [7:0]  buffer_size;
    phase_t      scan_phase;
    logic [3:0]  name_pos;
    logic [7:0]  high_digit;
    logic [7:0]  emitted;
    status_t     outcome;
    item_t       expected_items[$];
    int          errors;

    function new();
      name_chars  = '0;
      name_length = 4'd1;
      buffer_size = 8'd33;
      errors      = 0;
      start_string();
    endfunction

    function void start_string();
      scan_phase = PH_MATCH;
      name_pos   = '0;
      high_digit = '0;
      emitted    = '0;
      outcome    = ST_NOT_FOUND;
    endfunction

    function void set_register(logic [1:0] idx, logic [63:0] value);
      case (idx)
        CFG_NAME_CHARS:  name_chars  = value;
        CFG_NAME_LENGTH: name_length = value[3:0];
        CFG_BUFFER_SIZE: buffer_size = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] loose_digit(logic [7:0] c);
      if (c < 8'h3A) return c - 8'h30;
      if (c > 8'h60) return c - 8'h57;
      return c - 8'h37;
    endfunction

    function void push_item(kind_t kind, logic [7:0] value, status_t st, logic last);
      item_t it;
      it.kind       = kind;
      it.value_byte = value;
      it.status     = st;
      it.last_item  = last;
      expected_items.push_back(it);
    endfunction

    function void mark_too_long();
      outcome    = ST_TOO_LONG;
      scan_phase = PH_DONE;
    endfunction

    function void emit(logic [7:0] value);
      if (emitted >= buffer_size) begin
        mark_too_long();
        return;
      end
      push_item(KIND_BYTE, value, ST_FOUND, 1'b0);
      emitted++;
      if (emitted >= buffer_size) mark_too_long();
    endfunction

    function void note_request(logic [7:0] b, logic eos);
      int unsigned len;
      len = (name_length > MAX_NAME_LEN) ? MAX_NAME_LEN : name_length;
      case (scan_phase)
        PH_MATCH: begin
          if (name_pos < len) begin
            if (b == name_chars[name_pos*8 +: 8]) name_pos++;
            else if (b == CH_AMP) name_pos = '0;
            else scan_phase = PH_SKIP;
          end else if (b == CH_EQUALS) begin
            outcome    = ST_FOUND;
            scan_phase = PH_VALUE;
            if (buffer_size == 0) mark_too_long();
          end else if (b == CH_AMP) begin
            name_pos = '0;
          end else begin
            scan_phase = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (b == CH_AMP) begin
            scan_phase = PH_MATCH;
            name_pos   = '0;
          end
        end
        PH_VALUE: begin
          if (b == CH_AMP) scan_phase = PH_DONE;
          else if (emitted >= buffer_size) mark_too_long();
          else if (b == CH_PLUS) emit(CH_SPACE);
          else if (b == CH_PERCENT) scan_phase = PH_ESC1;
          else emit(b);
        end
        PH_ESC1: begin
          high_digit = loose_digit(b);
          scan_phase = PH_ESC2;
        end
        PH_ESC2: begin
          scan_phase = PH_VALUE;
          emit((high_digit << 4) + loose_digit(b));
        end
        default: ;
      endcase
      if (eos) begin
        push_item(KIND_STATUS, 8'h00, outcome, 1'b1);
        start_string();
      end
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic kind, logic [15:0] tdata, logic last);
      item_t want;
      if (expected_items.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual kind %b data %h last %b",
                 $time, kind, tdata, last);
        return;
      end
      want = expected_items.pop_front();
      compare("item_kind", 16'(want.kind), 16'(kind));
      compare("value_byte", 16'(want.value_byte), 16'(tdata[7:0]));
      compare("status", 16'(want.status), 16'(tdata[9:8]));
      compare("last_item", 16'(want.last_item), 16'(last));
      compare("tdata padding", 16'h0000, 16'(tdata[15:10]));
    endfunction

    function int pending();
      return expected_items.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  query_value_scoreboard sb;
  logic [7:0]  query_bytes[$];
  logic [63:0] cur_name;
  logic [3:0]  cur_len;
  bit          gaps_on;
  bit          hold_off_wanted;
  int          burst_left;
  int          bytes_sent;

  url_query_parameter_extractor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results are checked before the request of the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.note_request(in_tdata, in_tlast);
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stall pattern in segments, plus one long hold-off on demand
  initial begin : result_sink
    int span, mode, k;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_wanted) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_wanted = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (k = 0; k < span; k++) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (k % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 5));
    return 8'h61 + c;
  endfunction

  function automatic logic [7:0] hex_char();
    string hx = "0123456789abcdefABCDEF";
    return hx[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] random_name_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 9);
    if (r == 0) return CH_AMP;
    if (r == 1) return rand_byte();
    c = 8'($urandom_range(0, 2));
    return 8'h61 + c;
  endfunction

  function automatic void add_field_name(int eff);
    int r, n, i;
    r = $urandom_range(0, 9);
    if (r >= 8) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) query_bytes.push_back(pick_letter());
    end else begin
      // the name, or near misses: a short prefix, one extra letter, or the last letter altered
      n = (r == 5 && eff > 0) ? eff - 1 : eff;
      for (i = 0; i < n; i++)
        query_bytes.push_back((r == 7 && i == n - 1) ? cur_name[i*8 +: 8] ^ 8'h01
                                                     : cur_name[i*8 +: 8]);
      if (r == 6) query_bytes.push_back(pick_letter());
    end
  endfunction

  function automatic void add_field_value();
    int n, i;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        6: query_bytes.push_back(CH_PLUS);
        7: begin
          query_bytes.push_back(CH_PERCENT);
          query_bytes.push_back(hex_char());
          query_bytes.push_back(hex_char());
        end
        8: begin
          query_bytes.push_back(CH_PERCENT);
          query_bytes.push_back(rand_byte());
          query_bytes.push_back(rand_byte());
        end
        9: query_bytes.push_back(rand_byte());
        default: query_bytes.push_back(pick_letter());
      endcase
    end
  endfunction

  function automatic void build_query();
    int eff, f, nf;
    query_bytes.delete();
    eff = (cur_len > MAX_NAME_LEN) ? MAX_NAME_LEN : cur_len;
    if ($urandom_range(0, 11) == 0) begin
      nf = $urandom_range(1, 12);
      for (f = 0; f < nf; f++) query_bytes.push_back(rand_byte());
      return;
    end
    nf = $urandom_range(1, 4);
    for (f = 0; f < nf; f++) begin
      if (f > 0) query_bytes.push_back(CH_AMP);
      add_field_name(eff);
      if ($urandom_range(0, 9) != 0) query_bytes.push_back(CH_EQUALS);
      add_field_value();
    end
    // broken ending, may cut an escape short
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 2))
        if (query_bytes.size() > 2) void'(query_bytes.pop_back());
    if (query_bytes.size() == 0) query_bytes.push_back(pick_letter());
  endfunction

  function automatic void load_text(string s);
    int i;
    query_bytes.delete();
    for (i = 0; i < s.len(); i++) query_bytes.push_back(s[i]);
  endfunction

  task automatic send_byte(logic [7:0] b, logic eos);
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) burst_left--;
    bytes_sent++;
  endtask

  task automatic send_query();
    int i;
    for (i = 0; i < query_bytes.size(); i++)
      send_byte(query_bytes[i], i == query_bytes.size() - 1);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_register(cfg_idx_t idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // only called while idle; upper bits of the narrow registers carry junk
  task automatic configure(logic [63:0] chars, logic [3:0] len, logic [7:0] bsize);
    logic [63:0] junk;
    cur_name  = chars;
    cur_len   = len;
    write_register(CFG_NAME_CHARS, chars);
    junk = {$urandom(), $urandom()};
    junk[3:0] = len;
    write_register(CFG_NAME_LENGTH, junk);
    junk = {$urandom(), $urandom()};
    junk[7:0] = bsize;
    write_register(CFG_BUFFER_SIZE, junk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(int n);
    logic [63:0] chars;
    logic [3:0]  len;
    logic [7:0]  bsize;
    int i;
    for (i = 0; i < 8; i++) chars[i*8 +: 8] = random_name_char();
    len   = 4'($urandom_range(1, 8));
    bsize = ($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom_range(1, 24));
    case (n)
      0: configure('1, 4'd8, 8'd255);
      1: configure('0, 4'd0, 8'd1);
      3: configure(chars, 4'd15, 8'd0);
      4: configure(chars, 4'd1, 8'd1);
      default: configure(chars, len, bsize);
    endcase
  endtask

  initial begin : stimulus
    int directed_count, setting_no;
    sb = new();
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'h00;
    in_tlast   <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_NAME_CHARS;
    cfg_data   <= '0;
    gaps_on         = 1'b1;
    hold_off_wanted = 1'b0;
    burst_left      = 0;
    bytes_sent      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: name "ab", four-byte buffer
    configure(64'h5A5A_5A5A_5A5A_6261, 4'd2, 8'd4);
    load_text("q&ab=%4A+");
    query_bytes.push_back(8'hFF);
    send_query();
    load_text("ab=%&z");   // escape digits taken even when one is '&'
    send_query();
    load_text("ab=%");     // escape cut off by the end of the string
    send_query();
    load_text("ab=1234");  // fills the buffer
    send_query();
    drain_results();
    directed_count = bytes_sent;

    setting_no = 0;
    while (bytes_sent - directed_count < RANDOM_ITEMS) begin
      apply_setting(setting_no);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (setting_no == 2) begin
        // receiver holds off while requests keep coming, so the input backs up
        gaps_on = 1'b0;
        hold_off_wanted = 1'b1;
        while (hold_off_wanted) begin
          build_query();
          send_query();
        end
      end
      repeat ($urandom_range(2, 8)) begin
        build_query();
        send_query();
      end
      drain_results();
      setting_no++;
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
